// ----- rtl/thb_pkg.sv -----
// ----------------------------------------------------------------------------
// thb_pkg
// Shared widths, register indexes, reset values and constants of the NTC
// thermistor linearizer with EMA filter.
// ----------------------------------------------------------------------------
`default_nettype none

package thb_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int BETA_W  = 14;
    localparam int T0_W    = 16;
    localparam int RATIO_W = 20;
    localparam int ALPHA_W = 17;
    localparam int FAULT_W = 12;
    localparam int TEMP_W  = 17;

    localparam int OUT_W  = 40;
    localparam int USER_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_BETA       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NOMINAL_T0 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FAULT_LOW  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FAULT_HIGH = 3'd5;

    localparam logic [BETA_W-1:0]  BETA_RST       = 14'd3950;
    localparam logic [T0_W-1:0]    T0_RST         = 16'd29815;
    localparam logic [RATIO_W-1:0] RATIO_RST      = 20'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RST      = 17'd6554;
    localparam logic [FAULT_W-1:0] FAULT_LOW_RST  = 12'd10;
    localparam logic [FAULT_W-1:0] FAULT_HIGH_RST = 12'd4080;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -17'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd60000;
    localparam int KELVIN_OFFSET = 27315;

    // ln(2) in Q32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int MANT_W = 31;
    localparam int FRAC_W = 16;
    localparam int QUOT_W = 18;

endpackage

`default_nettype wire

// ----- rtl/thb_log2.sv -----
// ----------------------------------------------------------------------------
// thb_log2
// Iterative log2 in Q16: one-bit-a-cycle normalization, then mantissa
// squarings, one fraction bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module thb_log2 import thb_pkg::*; #(
    parameter int XW = 36,
    parameter int PW = 6,
    parameter int RW = 22
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [XW-1:0] x,
    output logic               done,
    output logic [RW-1:0]      res
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQR  = 2'd2;

    logic [1:0]        st_reg;
    logic [XW-1:0]     x_reg;
    logic [PW-1:0]     p_reg;
    logic [MANT_W-1:0] m_reg;
    logic [3:0]        i_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              done_reg;

    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     m2;

    assign sq = {{MANT_W{1'b0}}, m_reg} * {{MANT_W{1'b0}}, m_reg};
    // The square of a Q30 mantissa, brought back to Q30.
    assign m2 = sq[2*MANT_W-1 -: MANT_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= L_IDLE;
            done_reg <= 1'b0;
        end else begin
            case (st_reg)
                L_IDLE: begin
                    done_reg <= start && (x == '0);
                    if (start) begin
                        x_reg    <= x;
                        frac_reg <= '0;
                        if (x == '0) begin
                            p_reg <= '0;
                        end else begin
                            p_reg  <= PW'(XW-1);
                            st_reg <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    done_reg <= 1'b0;
                    if (x_reg[XW-1]) begin
                        m_reg  <= x_reg[XW-1 -: MANT_W];
                        i_reg  <= 4'd15;
                        st_reg <= L_SQR;
                    end else begin
                        x_reg <= {x_reg[XW-2:0], 1'b0};
                        p_reg <= p_reg - 1'b1;
                    end
                end
                L_SQR: begin
                    // The squared mantissa lies in [1, 4); a value of 2 or more
                    // yields a one in this fraction bit.
                    if (m2[MANT_W]) begin
                        m_reg           <= m2[MANT_W:1];
                        frac_reg[i_reg] <= 1'b1;
                    end else begin
                        m_reg <= m2[MANT_W-1:0];
                    end
                    done_reg <= (i_reg == 4'd0);
                    if (i_reg == 4'd0) begin
                        st_reg <= L_IDLE;
                    end else begin
                        i_reg <= i_reg - 1'b1;
                    end
                end
                default: begin
                    done_reg <= 1'b0;
                    st_reg   <= L_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = RW'({p_reg, frac_reg});

endmodule

`default_nettype wire

// ----- rtl/thermistor_beta_linearizer_ema_unit.sv -----
// ----------------------------------------------------------------------------
// thermistor_beta_linearizer_ema_unit
// NTC divider sample to Celsius centidegrees by the beta equation, with an
// exponential moving average and a fault window flag.
// ----------------------------------------------------------------------------
// One ADC sample enters per s_ beat (low ADC_BITS bits of s_tdata). Each
// sample yields one m_ beat: raw and filtered temperature in signed
// centidegrees in m_tdata, the window fault flag in m_tuser.
// Samples are processed one at a time. Each result passes, in order, the
// product ratio * (FS - sample), a log2 of it and a log2 of the sample in
// the shared log2 unit (one-bit-a-cycle normalization and squaring steps),
// the conversion to ln, the denominator, the restoring divider and the
// filter steps. A zero sample or a zero resistance skips the log2 and
// divider steps, and a saturated or zero-beta result skips the divider.
// The input is ready again in the same cycle that the result beat appears.
// If the receiver stalls, the block finishes the next sample up to the final
// filter step and holds there until the output register frees.
// Configuration writes take effect at once; the user must make them only
// while idle, which the block itself does not enforce.
// Reset (aresetn low, synchronous) restores the register defaults, empties
// the output register and clears the filter, so the next sample seeds it.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_beta_linearizer_ema_unit import thb_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: adc_sample
    input  wire logic [((ADC_BITS+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: raw_temp_centi [16:0], filtered_temp_centi [33:17]
    output logic [OUT_W-1:0]                   m_tdata,
    // m_tuser: sensor_fault
    output logic [USER_W-1:0]                  m_tuser
);

    localparam int NRW   = RATIO_W + ADC_BITS;
    localparam int LOG_W = (NRW > MANT_W) ? NRW : MANT_W;
    localparam int PW    = $clog2(LOG_W);
    localparam int LRW   = PW + FRAC_W;
    localparam int L2W   = LRW + 2;
    localparam int MAGW  = L2W - 1 + 32;
    localparam int BT_W  = BETA_W + 7;
    localparam int BTT_W = BT_W + T0_W;
    localparam int TL_W  = T0_W + 1 + L2W;
    localparam int DW    = TL_W + 1;
    localparam int NUMW  = BTT_W + FRAC_W;
    localparam int CW    = (NUMW + 1 > DW - 1 + QUOT_W) ? NUMW + 1 : DW - 1 + QUOT_W;
    localparam int FCW   = (ADC_BITS > FAULT_W) ? ADC_BITS : FAULT_W;
    localparam int QCW   = $clog2(QUOT_W);
    localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};
    localparam logic [QUOT_W-1:0] T_HI = QUOT_W'(60000 + KELVIN_OFFSET);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_L1S  = 4'd2;
    localparam logic [3:0] S_L1W  = 4'd3;
    localparam logic [3:0] S_L2W  = 4'd4;
    localparam logic [3:0] S_LN   = 4'd5;
    localparam logic [3:0] S_LNR  = 4'd6;
    localparam logic [3:0] S_DEN  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_EMA1 = 4'd11;
    localparam logic [3:0] S_EMA2 = 4'd12;

    logic [BETA_W-1:0]  beta_reg;
    logic [T0_W-1:0]    t0_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [FAULT_W-1:0] flow_reg;
    logic [FAULT_W-1:0] fhigh_reg;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic [ADC_BITS-1:0]      s_reg;
    logic                     fault_reg;
    logic [NRW-1:0]           numr_reg;
    logic [BT_W-1:0]          bt_reg;
    logic [BTT_W-1:0]         btt_reg;
    logic [LRW-1:0]           l1_reg;
    logic signed [L2W-1:0]    l2_reg;
    logic [MAGW-1:0]          mag_reg;
    logic signed [L2W-1:0]    lnq_reg;
    logic signed [DW-1:0]     den_reg;
    logic [CW-1:0]            rem_reg;
    logic [CW-1:0]            dsh_reg;
    logic [QUOT_W-1:0]        q_reg;
    logic [QCW-1:0]           cnt_reg;
    logic signed [TEMP_W-1:0] raw_reg;
    logic signed [31:0]       fv_reg;
    logic                     seeded_reg;
    logic signed [31:0]       fuse_reg;
    logic signed [50:0]       prod_reg;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         out_data_reg;
    logic                     out_fault_reg;

    logic              log_start;
    logic [LOG_W-1:0]  log_x;
    logic              log_done;
    logic [LRW-1:0]    log_res;

    logic               s_accept;
    logic               out_free;
    logic [FCW-1:0]     s_ext;
    logic [ADC_BITS-1:0] s_in;
    logic signed [L2W-1:0]   l2_next;
    logic [L2W-2:0]          l2_abs;
    logic [MAGW-1:0]         mag_rnd;
    logic [L2W-2:0]          lnq_mag;
    logic signed [T0_W:0]    t0_s;
    logic signed [TL_W-1:0]  tl_prod;
    logic signed [DW-1:0]    tl_ext;
    logic signed [DW-1:0]    bt_sh;
    logic [CW-1:0]           nn;
    logic [CW-1:0]           dlim;
    logic                    rem_ge;
    logic [ALPHA_W-1:0]      a_eff;
    logic signed [31:0]      raw_q8;
    logic signed [31:0]      fv_use;
    logic signed [32:0]      diff;
    logic signed [51:0]      sum;
    logic signed [31:0]      fv_new;
    logic signed [32:0]      filt_tmp;

    assign s_in     = s_tdata[ADC_BITS-1:0];
    assign s_ext    = FCW'(s_in);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign log_start = (state_reg == S_L1S && numr_reg != '0) ||
                       (state_reg == S_L1W && log_done);
    assign log_x     = (state_reg == S_L1S) ? LOG_W'(numr_reg) : LOG_W'(s_reg);

    thb_log2 #(
        .XW (LOG_W),
        .PW (PW),
        .RW (LRW)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .x       (log_x),
        .done    (log_done),
        .res     (log_res)
    );

    // log2 of the ratio: log2(ratio * (FS - s)) - log2(s) - 16
    assign l2_next = $signed({2'b00, l1_reg}) - $signed({2'b00, log_res})
                     - $signed(L2W'(32'd1048576));
    assign l2_abs  = l2_reg[L2W-1] ? (L2W-1)'(-l2_reg) : l2_reg[L2W-2:0];
    assign mag_rnd = mag_reg + MAGW'(33'h080000000);
    assign lnq_mag = mag_rnd[MAGW-1:32];

    assign t0_s    = $signed({1'b0, t0_reg});
    assign tl_prod = t0_s * lnq_reg;
    assign tl_ext  = DW'(tl_prod);
    assign bt_sh   = $signed(DW'({bt_reg, {FRAC_W{1'b0}}}));

    assign nn     = CW'({btt_reg, {FRAC_W{1'b0}}}) + CW'(den_reg[DW-2:1]);
    assign dlim   = CW'(den_reg[DW-2:0]) << QUOT_W;
    assign rem_ge = (rem_reg >= dsh_reg);

    assign a_eff  = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign raw_q8 = {{7{raw_reg[TEMP_W-1]}}, raw_reg, 8'd0};
    assign fv_use = seeded_reg ? fv_reg : raw_q8;
    assign diff   = {raw_q8[31], raw_q8} - {fv_use[31], fv_use};

    assign sum      = {{4{fuse_reg[31]}}, fuse_reg, 16'd0} + {prod_reg[50], prod_reg}
                      + 52'sd32768;
    assign fv_new   = sum[47:16];
    assign filt_tmp = {fv_new[31], fv_new} + 33'sd128;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_accept) state_next = S_MUL;
            S_MUL:  state_next = (s_reg == '0) ? S_EMA1 : S_L1S;
            S_L1S:  state_next = (numr_reg == '0) ? S_EMA1 : S_L1W;
            S_L1W:  if (log_done) state_next = S_L2W;
            S_L2W:  if (log_done) state_next = S_LN;
            S_LN:   state_next = S_LNR;
            S_LNR:  state_next = S_DEN;
            S_DEN:  state_next = S_CHK;
            S_CHK: begin
                if (btt_reg == '0 || den_reg <= 0 || nn >= dlim) begin
                    state_next = S_EMA1;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV:  if (cnt_reg == '0) state_next = S_FIN;
            S_FIN:  state_next = S_EMA1;
            S_EMA1: state_next = S_EMA2;
            S_EMA2: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            seeded_reg    <= 1'b0;
            fv_reg        <= '0;
            beta_reg      <= BETA_RST;
            t0_reg        <= T0_RST;
            ratio_reg     <= RATIO_RST;
            alpha_reg     <= ALPHA_RST;
            flow_reg      <= FAULT_LOW_RST;
            fhigh_reg     <= FAULT_HIGH_RST;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_addr)
                    REG_BETA:       beta_reg  <= cfg_wdata[BETA_W-1:0];
                    REG_NOMINAL_T0: t0_reg    <= cfg_wdata[T0_W-1:0];
                    REG_RATIO:      ratio_reg <= cfg_wdata[RATIO_W-1:0];
                    REG_ALPHA:      alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    REG_FAULT_LOW:  flow_reg  <= cfg_wdata[FAULT_W-1:0];
                    REG_FAULT_HIGH: fhigh_reg <= cfg_wdata[FAULT_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == S_EMA2 && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        s_reg     <= s_in;
                        fault_reg <= (s_ext < FCW'(flow_reg)) || (s_ext > FCW'(fhigh_reg));
                    end
                end
                S_MUL: begin
                    numr_reg <= NRW'(ratio_reg) * NRW'(FULL_SCALE - s_reg);
                    bt_reg   <= BT_W'(beta_reg) * BT_W'(7'd100);
                    raw_reg  <= TEMP_MIN;
                end
                S_L1W: if (log_done) l1_reg <= log_res;
                S_L2W: if (log_done) l2_reg <= l2_next;
                S_LN: begin
                    mag_reg <= MAGW'(l2_abs) * MAGW'(LN2_Q32);
                    btt_reg <= BTT_W'(bt_reg) * BTT_W'(t0_reg);
                end
                S_LNR: begin
                    // Round on the magnitude, then take the sign back.
                    lnq_reg <= l2_reg[L2W-1] ? -$signed({1'b0, lnq_mag})
                                             : $signed({1'b0, lnq_mag});
                end
                S_DEN: den_reg <= bt_sh + tl_ext;
                S_CHK: begin
                    if (btt_reg == '0) begin
                        raw_reg <= TEMP_MIN;
                    end else if (den_reg <= 0 || nn >= dlim) begin
                        raw_reg <= TEMP_MAX;
                    end else begin
                        rem_reg <= nn;
                        dsh_reg <= CW'(den_reg[DW-2:0]) << (QUOT_W - 1);
                        q_reg   <= '0;
                        cnt_reg <= QCW'(QUOT_W - 1);
                    end
                end
                S_DIV: begin
                    if (rem_ge) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg   <= {q_reg[QUOT_W-2:0], rem_ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                S_FIN: begin
                    if (q_reg > T_HI) begin
                        raw_reg <= TEMP_MAX;
                    end else begin
                        raw_reg <= TEMP_W'($signed({1'b0, q_reg}) - KELVIN_OFFSET);
                    end
                end
                S_EMA1: begin
                    fuse_reg <= fv_use;
                    prod_reg <= diff * $signed({1'b0, a_eff});
                end
                S_EMA2: begin
                    if (out_free) begin
                        fv_reg        <= fv_new;
                        seeded_reg    <= 1'b1;
                        out_data_reg  <= OUT_W'({filt_tmp[24:8], raw_reg});
                        out_fault_reg <= fault_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fault_reg;

endmodule

`default_nettype wire

// ----- rtl/thb_checker.sv -----
// ----------------------------------------------------------------------------
// thb_checker
// Port-level checks of the thermistor linearizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module thb_checker import thb_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_W-1:0]  m_tdata,
    input wire logic [USER_W-1:0] m_tuser
);

    // Samples are worked one at a time, so an accepted beat closes the input.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    a_raw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[16:0]) >= -27315 && $signed(m_tdata[16:0]) <= 60000))
        else $error("raw temperature out of range");

    a_filt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[33:17]) >= -27315 && $signed(m_tdata[33:17]) <= 60000))
        else $error("filtered temperature out of range");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind thermistor_beta_linearizer_ema_unit thb_checker u_thb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/sv/thermistor_beta_linearizer_ema_unit_tb.sv -----
// ----------------------------------------------------------------------------
// thermistor_beta_linearizer_ema_unit_tb
// Drives ADC samples into the thermistor linearizer and compares every output
// beat against an in-bench fixed-point model of the beta equation, the EMA
// filter and the fault window, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermistor_beta_linearizer_ema_unit_tb import thb_pkg::*; ();

    typedef struct packed {
        logic signed [TEMP_W-1:0] raw_temp;
        logic signed [TEMP_W-1:0] filt_temp;
        logic                     fault;
    } temp_result_t;

    // Register copies and filter state of the temperature predictor.
    class temp_scoreboard;
        longint unsigned beta, t0, ratio, alpha, flo, fhi;
        longint filt_q8;
        bit seeded;
        temp_result_t pending[$];
        int errors;

        function void clear();
            beta = BETA_RST; t0 = T0_RST; ratio = RATIO_RST; alpha = ALPHA_RST;
            flo = FAULT_LOW_RST; fhi = FAULT_HIGH_RST;
            filt_q8 = 0; seeded = 0; errors = 0;
            pending.delete();
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, longint unsigned v);
            case (idx)
                REG_BETA:       beta  = v & 14'h3FFF;
                REG_NOMINAL_T0: t0    = v & 16'hFFFF;
                REG_RATIO:      ratio = v & 20'hFFFFF;
                REG_ALPHA:      alpha = v & 17'h1FFFF;
                REG_FAULT_LOW:  flo   = v & 12'hFFF;
                REG_FAULT_HIGH: fhi   = v & 12'hFFF;
                default: ;
            endcase
        endfunction

        function longint log2_fix(longint unsigned x);
            int p;
            longint unsigned m;
            longint r;
            p = 63;
            while (x[p] == 1'b0) p--;
            m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
            r = longint'(p) * 65536;
            for (int i = 15; i >= 0; i--) begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30)) begin
                    m = m >> 1;
                    r += longint'(1) << i;
                end
            end
            return r;
        endfunction

        function longint celsius_of(longint unsigned s);
            longint unsigned nr, mag;
            longint l2, lnq, num, den, t, c;
            if (s == 0) return -27315;
            nr = ratio * (64'd4095 - s);
            if (nr == 0) return -27315;
            l2 = log2_fix(nr) - log2_fix(s) - 16 * 65536;
            mag = longint'(l2 < 0 ? -l2 : l2) * 64'd2977044472;
            lnq = longint'((mag + (64'd1 << 31)) >> 32);
            if (l2 < 0) lnq = -lnq;
            num = 100 * longint'(beta) * longint'(t0) * 65536;
            if (num == 0) return -27315;
            den = 100 * longint'(beta) * 65536 + longint'(t0) * lnq;
            if (den <= 0) return 60000;
            t = (num + den / 2) / den;
            c = t - KELVIN_OFFSET;
            if (c > 60000) c = 60000;
            if (c < -27315) c = -27315;
            return c;
        endfunction

        function void note_sample(logic [11:0] s);
            longint raw, a, sum, fo;
            longint bias;
            temp_result_t r;
            bias = longint'(1) << 23;
            raw = celsius_of(s);
            a = (alpha > 65536) ? 65536 : longint'(alpha);
            if (!seeded) begin
                filt_q8 = raw * 256;
                seeded = 1;
            end
            sum = a * raw * 256 + (65536 - a) * filt_q8 + (bias << 16) + 32768;
            filt_q8 = (sum >>> 16) - bias;
            fo = ((filt_q8 + bias + 128) >>> 8) - (bias >>> 8);
            r.raw_temp = raw[TEMP_W-1:0];
            r.filt_temp = fo[TEMP_W-1:0];
            r.fault = (s < flo) || (s > fhi);
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] data, logic [USER_W-1:0] user);
            temp_result_t w;
            if (pending.size() == 0) begin
                report("unexpected beat", data, 0);
                return;
            end
            w = pending.pop_front();
            if ($signed(data[16:0]) != w.raw_temp)
                report("raw_temp_centi", $signed(data[16:0]), w.raw_temp);
            if ($signed(data[33:17]) != w.filt_temp)
                report("filtered_temp_centi", $signed(data[33:17]), w.filt_temp);
            if (user[0] != w.fault) report("sensor_fault", user[0], w.fault);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;

    temp_scoreboard board = new();
    int cycle_count = 0;
    bit hold_off = 0;
    localparam int CYCLE_LIMIT = 5_000_000;

    always #4 aclk = ~aclk;

    thermistor_beta_linearizer_ema_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: accept and check, with random stalls.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end

    initial begin
        int g;
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
                g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v[CFG_DATA_W-1:0];
        @(posedge aclk);
        board.set_reg(idx, v);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_sample(logic [11:0] s, bit gaps);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= {4'h0, s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_sample(s);
        @(negedge aclk);
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        // Each sample is fully retired by the time its beat is taken.
        repeat (200) @(negedge aclk);
    endtask

    task automatic random_samples(int n);
        logic [11:0] s;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: s = $urandom_range(0, 15);
                1: s = $urandom_range(4080, 4095);
                default: s = $urandom_range(0, 4095);
            endcase
            send_sample(s, $urandom_range(0, 4) != 0);
        end
    endtask

    initial begin
        logic [11:0] edges[$];
        edges = '{12'd0, 12'd1, 12'd9, 12'd10, 12'd11, 12'd2047, 12'd2048,
                  12'd4079, 12'd4080, 12'd4081, 12'd4094, 12'd4095,
                  12'hAAA, 12'h555};
        board.clear();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Defaults, boundary samples, back-to-back.
        foreach (edges[i]) send_sample(edges[i], 0);
        drain();

        // Extremes: zero beta, zero ratio, hot saturation, zero T0, then full-scale
        write_reg(REG_BETA, 0);
        send_sample(12'd2000, 0);
        drain();
        write_reg(REG_BETA, 3950);
        write_reg(REG_RATIO, 0);
        send_sample(12'd2000, 0);
        drain();
        write_reg(REG_BETA, 1000);
        write_reg(REG_NOMINAL_T0, 40000);
        write_reg(REG_RATIO, 1);
        write_reg(REG_ALPHA, 65536);
        write_reg(REG_FAULT_LOW, 0);
        write_reg(REG_FAULT_HIGH, 4095);
        send_sample(12'd4000, 0);
        send_sample(12'd3, 0);
        send_sample(12'd4094, 0);
        drain();
        write_reg(REG_NOMINAL_T0, 0);
        send_sample(12'd100, 0);
        drain();
        write_reg(REG_BETA, 16383);
        write_reg(REG_NOMINAL_T0, 20000);
        write_reg(REG_RATIO, 1048575);
        write_reg(REG_ALPHA, 131071);
        write_reg(REG_FAULT_LOW, 4095);
        write_reg(REG_FAULT_HIGH, 0);
        send_sample(12'd1, 0);
        send_sample(12'd4095, 0);
        drain();

        // Receiver holds off while samples keep coming.
        write_reg(REG_ALPHA, 0);
        fork
            begin
                hold_off = 1;
                repeat (1500) @(negedge aclk);
                hold_off = 0;
            end
            random_samples(6);
        join
        drain();

        // Random phases over random settings.
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_BETA, $urandom_range(1000, 10000));
            write_reg(REG_NOMINAL_T0, $urandom_range(20000, 40000));
            write_reg(REG_RATIO, (ph == 0) ? 1 : (ph == 1) ? 1048575 :
                      $urandom_range(4096, 262144));
            write_reg(REG_ALPHA, (ph == 2) ? 0 : (ph == 3) ? 65536 :
                      $urandom_range(0, 70000));
            write_reg(REG_FAULT_LOW, $urandom_range(0, 200));
            write_reg(REG_FAULT_HIGH, $urandom_range(3800, 4095));
            random_samples(185);
            drain();
        end

        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/thb_pkg.sv
rtl/thb_log2.sv
rtl/thermistor_beta_linearizer_ema_unit.sv
rtl/thb_checker.sv
tb/sv/thermistor_beta_linearizer_ema_unit_tb.sv
